// ----- sv/catmull_rom_curve_sampler_macros.svh -----
// Assertion macros for the Catmull-Rom curve sampler.
// Used by the top level only; expects signals named clk and rst_n in scope.
`ifndef CATMULL_ROM_CURVE_SAMPLER_MACROS_SVH
`define CATMULL_ROM_CURVE_SAMPLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crs assertion failed");

// Next-cycle implication, checked outside reset.
`define CRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crs assertion failed");

`endif

// ----- sv/crs_pkg.sv -----
// Shared constants and types for the Catmull-Rom curve sampler.
// No dependencies; imported by crs_mac and the top level.
package crs_pkg;

    // Default coordinate width (signed Q8.8).
    localparam int COORD_BITS_DEF = 16;

    // Step shift register width and its largest effective value.
    localparam int                 SHIFT_W   = 3;
    localparam logic [SHIFT_W-1:0] MAX_SHIFT = 3'd5;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 3'd5;

    // Sample index width: holds 0 .. 2^MAX_SHIFT.
    localparam int K_W = 6;

    // Phases of the shared multiply-add unit (Horner evaluation).
    localparam logic [1:0] PH_CUBIC = 2'd0;
    localparam logic [1:0] PH_QUAD  = 2'd1;
    localparam logic [1:0] PH_LIN   = 2'd2;
    localparam logic [1:0] PH_ROUND = 2'd3;

    // Control word from the sequencer to the multiply-add unit.
    typedef struct packed {
        logic               en;
        logic [1:0]         phase;
        logic [SHIFT_W-1:0] shift;
    } mac_ctrl_t;

endpackage

// ----- sv/crs_mac.sv -----
// Shared multiply-add unit: Horner evaluation of one curve sample for one axis,
// followed by rounding and saturation. Depends on crs_pkg.
module crs_mac
    import crs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  mac_ctrl_t                    ctrl,
    input  logic [K_W-1:0]               k,
    input  logic signed [COORD_BITS+3:0] coef_c,
    input  logic signed [COORD_BITS+3:0] coef_b,
    input  logic signed [COORD_BITS+3:0] coef_a,
    input  logic signed [COORD_BITS-1:0] p1,
    output logic signed [COORD_BITS-1:0] result
);

    localparam int AW = COORD_BITS + 21;

    localparam logic signed [AW-1:0] SAT_HI =
        $signed({{(AW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
    localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

    logic signed [AW-1:0]    acc_reg;
    logic signed [AW-1:0]    acc_next;
    logic signed [AW-1:0]    mul_src;
    logic signed [AW-1:0]    addend;
    logic signed [AW+K_W:0]  prod;
    logic signed [AW-1:0]    rnd;
    logic signed [AW-1:0]    shd;
    logic [4:0]              sh3;

    // Three times the step shift: the exponent of n^3.
    assign sh3 = 5'(ctrl.shift) + 5'({ctrl.shift, 1'b0});

    // Operand selection: the cubic step starts from C, later steps reuse the sum.
    always_comb
    begin
        mul_src = acc_reg;
        addend  = '0;
        case (ctrl.phase)
            PH_CUBIC:
            begin
                mul_src = AW'(coef_c);
                addend  = AW'(coef_b) <<< ctrl.shift;
            end
            PH_QUAD:
            begin
                addend = AW'(coef_a) <<< {ctrl.shift, 1'b0};
            end
            PH_LIN:
            begin
                addend = AW'(p1) <<< (sh3 + 5'd1);
            end
            default:
            begin
                addend = '0;
            end
        endcase
    end

    // One multiply by the sample index and one add per cycle.
    assign prod     = mul_src * $signed({1'b0, k});
    assign acc_next = prod[AW-1:0] + addend;

    always_ff @(posedge clk)
    begin
        if (ctrl.en && (ctrl.phase != PH_ROUND))
        begin
            acc_reg <= acc_next;
        end
    end

    // Round to nearest with ties upward, divide by 2*n^3, then saturate.
    assign rnd = acc_reg + (AW'(1) <<< sh3);
    assign shd = rnd >>> (sh3 + 5'd1);

    always_comb
    begin
        if (shd > SAT_HI)
        begin
            result = SAT_HI[COORD_BITS-1:0];
        end
        else if (shd < SAT_LO)
        begin
            result = SAT_LO[COORD_BITS-1:0];
        end
        else
        begin
            result = shd[COORD_BITS-1:0];
        end
    end

endmodule

// ----- sv/catmull_rom_curve_sampler.sv -----
// Catmull-Rom curve sampler: three-point window, sequencer and output register.
// A closing point passes a setup state, then yields 2^s + 1 samples, each run
// on the shared multiply-add unit through its cubic, quadratic, linear and
// rounding phases, x then y, and held in the output register until taken.
// A window-filling point is taken at once; the input stalls while sampling.
// Reset clears the window count, the sequencer and the step shift (to five).
`include "catmull_rom_curve_sampler_macros.svh"

module catmull_rom_curve_sampler
    import crs_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_shift_we,
    input  logic [SHIFT_W-1:0]           step_shift_data,
    input  logic                         point_valid,
    output logic                         point_stall,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic                         restart,
    output logic                         curve_valid,
    input  logic                         curve_stall,
    output logic signed [COORD_BITS-1:0] curve_x,
    output logic signed [COORD_BITS-1:0] curve_y,
    output logic                         last_sample
);

    localparam int CW = COORD_BITS + 4;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_CALC  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // Control state.
    logic [1:0]         state_reg, state_next;
    logic [1:0]         count_reg, count_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic [SHIFT_W-1:0] s_reg, s_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [1:0]         phase_reg, phase_next;
    logic               axis_reg, axis_next;
    logic               valid_reg, valid_next;

    // Payload state.
    logic signed [COORD_BITS-1:0] held_reg [2][3];
    logic signed [COORD_BITS-1:0] p3_reg   [2];
    logic signed [CW-1:0]         ca_reg   [2];
    logic signed [CW-1:0]         cb_reg   [2];
    logic signed [CW-1:0]         cc_reg   [2];
    logic signed [COORD_BITS-1:0] cp1_reg  [2];
    logic signed [CW-1:0]         ca_next  [2];
    logic signed [CW-1:0]         cb_next  [2];
    logic signed [CW-1:0]         cc_next  [2];
    logic signed [COORD_BITS-1:0] res_x_reg;
    logic signed [COORD_BITS-1:0] out_x_reg;
    logic signed [COORD_BITS-1:0] out_y_reg;
    logic                         last_reg;

    logic                         in_beat;
    logic                         out_beat;
    logic                         fill;
    logic                         sample_done;
    logic                         is_last;
    logic [1:0]                   fill_idx;
    mac_ctrl_t                    mac_ctrl;
    logic signed [COORD_BITS-1:0] mac_result;

    assign point_stall = (state_reg != ST_IDLE);
    assign in_beat     = point_valid && !point_stall;
    assign out_beat    = valid_reg && !curve_stall;
    assign fill        = restart || (count_reg != 2'd3);
    assign fill_idx    = restart ? 2'd0 : count_reg;
    assign sample_done = (phase_reg == PH_ROUND) && axis_reg;
    assign is_last     = (k_reg == (K_W'(1) << s_reg));

    // Segment coefficients from the window and the closing point, per axis.
    always_comb
    begin
        for (int ax = 0; ax < 2; ax++)
        begin
            ca_next[ax] = CW'(held_reg[ax][2]) - CW'(held_reg[ax][0]);
            cb_next[ax] = (CW'(held_reg[ax][0]) <<< 1) - (CW'(held_reg[ax][1]) <<< 2)
                        - CW'(held_reg[ax][1]) + (CW'(held_reg[ax][2]) <<< 2)
                        - CW'(p3_reg[ax]);
            cc_next[ax] = (CW'(held_reg[ax][1]) <<< 1) + CW'(held_reg[ax][1])
                        - CW'(held_reg[ax][0]) - (CW'(held_reg[ax][2]) <<< 1)
                        - CW'(held_reg[ax][2]) + CW'(p3_reg[ax]);
        end
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        shift_next = step_shift_we ? step_shift_data : shift_reg;
        s_next     = s_reg;
        k_next     = k_reg;
        phase_next = phase_reg;
        axis_next  = axis_reg;
        valid_next = valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (fill)
                    begin
                        count_next = fill_idx + 2'd1;
                    end
                    else
                    begin
                        s_next     = (shift_reg > MAX_SHIFT) ? MAX_SHIFT : shift_reg;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                k_next     = '0;
                phase_next = PH_CUBIC;
                axis_next  = 1'b0;
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == PH_ROUND)
                begin
                    axis_next = !axis_reg;
                end
                if (sample_done)
                begin
                    valid_next = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_beat)
                begin
                    valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + K_W'(1);
                        phase_next = PH_CUBIC;
                        axis_next  = 1'b0;
                        state_next = ST_CALC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= 2'd0;
            shift_reg <= SHIFT_RST;
            s_reg     <= MAX_SHIFT;
            k_reg     <= '0;
            phase_reg <= PH_CUBIC;
            axis_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
            s_reg     <= s_next;
            k_reg     <= k_next;
            phase_reg <= phase_next;
            axis_reg  <= axis_next;
            valid_reg <= valid_next;
        end
    end

    // Window, coefficients and results.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            if (fill)
            begin
                held_reg[0][fill_idx] <= point_x;
                held_reg[1][fill_idx] <= point_y;
            end
            else
            begin
                p3_reg[0] <= point_x;
                p3_reg[1] <= point_y;
            end
        end
        if (state_reg == ST_SETUP)
        begin
            for (int ax = 0; ax < 2; ax++)
            begin
                ca_reg[ax]      <= ca_next[ax];
                cb_reg[ax]      <= cb_next[ax];
                cc_reg[ax]      <= cc_next[ax];
                cp1_reg[ax]     <= held_reg[ax][1];
                held_reg[ax][0] <= held_reg[ax][1];
                held_reg[ax][1] <= held_reg[ax][2];
                held_reg[ax][2] <= p3_reg[ax];
            end
        end
        if ((state_reg == ST_CALC) && (phase_reg == PH_ROUND))
        begin
            if (!axis_reg)
            begin
                res_x_reg <= mac_result;
            end
            else
            begin
                out_x_reg <= res_x_reg;
                out_y_reg <= mac_result;
                last_reg  <= is_last;
            end
        end
    end

    // Shared multiply-add unit, fed with the current axis.
    assign mac_ctrl.en    = (state_reg == ST_CALC);
    assign mac_ctrl.phase = phase_reg;
    assign mac_ctrl.shift = s_reg;

    crs_mac #(
        .COORD_BITS (COORD_BITS)
    ) u_mac (
        .clk    (clk),
        .ctrl   (mac_ctrl),
        .k      (k_reg),
        .coef_c (cc_reg[axis_reg]),
        .coef_b (cb_reg[axis_reg]),
        .coef_a (ca_reg[axis_reg]),
        .p1     (cp1_reg[axis_reg]),
        .result (mac_result)
    );

    assign curve_valid = valid_reg;
    assign curve_x     = out_x_reg;
    assign curve_y     = out_y_reg;
    assign last_sample = last_reg;

    // A segment is only started with a full window.
    `CRS_ASSERT_IMP(a_setup_full, state_reg == ST_SETUP, count_reg == 2'd3)
    // While sampling, the sample index never passes the segment end.
    `CRS_ASSERT_IMP(a_k_range, (state_reg == ST_CALC) || (state_reg == ST_EMIT), k_reg <= (K_W'(1) << s_reg))
    // The final beat of a segment returns the sequencer to idle.
    `CRS_ASSERT_NXT(a_last_idle, out_beat && last_reg, state_reg == ST_IDLE)
    // An accepted point always leaves at least one point held.
    `CRS_ASSERT_NXT(a_count_nz, in_beat, count_reg != 2'd0)

endmodule
